// ----- sv/ntrl_pkg.sv -----
// Shared types and codes for the NTFS run list decoder.
// Holds the beat structs, record and error codes, and a record builder.
// No dependencies.
package ntrl_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } ntrl_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  error_code;
    logic [63:0] cluster_count;
    logic [62:0] start_lcn;
    logic        is_sparse;
    logic        last_of_item;
  } ntrl_out_t;

  // Records handed from the decode stage to the output queue together.
  typedef struct packed {
    logic [1:0] num;
    ntrl_out_t  first;
    ntrl_out_t  second;
  } ntrl_push_t;

  localparam logic [1:0] KIND_RUN = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
  localparam logic [2:0] ERR_ZERO_COUNT = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
  localparam logic [2:0] ERR_LCN_RANGE  = 3'd4;
  localparam logic [2:0] ERR_EMPTY      = 3'd5;

  function automatic ntrl_out_t make_rec(logic [1:0] kind, logic [2:0] err,
                                         logic [63:0] cnt, logic [62:0] lcn,
                                         logic sparse);
    ntrl_out_t r;
    r.record_kind   = kind;
    r.error_code    = err;
    r.cluster_count = cnt;
    r.start_lcn     = lcn;
    r.is_sparse     = sparse;
    r.last_of_item  = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/ntfs_run_list_decoder.sv -----
// Top level of the NTFS run list decoder: decode stage plus result queue.
// Depends on ntrl_pkg, ntrl_core and ntrl_outq.
//
//   channel   valid/ready              payload     beat
//   --------  -----------------------  ----------  ------------------------
//   input     byte_valid / byte_ready  byte_data   one run list byte + flag
//   output    rec_valid / rec_ready    rec_data    one run, end or error rec
//
// One byte per cycle. A byte is held in the input register, decoded into the
// four-entry queue once the queue has room, and its first record is then shown
// from the queue's registered slot. A run ending on the final byte gives two
// records, drained one per cycle while rec_ready is high. Input stalls only
// while the queue holds more than two records. rst is synchronous and returns
// the decoder to expect-header with an empty queue.
module ntfs_run_list_decoder import ntrl_pkg::*; #(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  ntrl_in_t  byte_data,
  output logic      rec_valid,
  input  logic      rec_ready,
  output ntrl_out_t rec_data
);

  ntrl_push_t push;
  logic       room;

  ntrl_core #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .room      (room),
    .push      (push)
  );

  ntrl_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .rec_data (rec_data)
  );

endmodule

// ----- sv/ntrl_core.sv -----
// Decode stage of the run list decoder: input register, run state, field
// gathering and LCN update. Depends on ntrl_pkg.
module ntrl_core import ntrl_pkg::*; #(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  ntrl_in_t   byte_data,
  input  logic       room,
  output ntrl_push_t push
);

  localparam int         ACC_W    = 8 * MAX_FIELD_BYTES;
  localparam logic [3:0] MAX_NIB  = 4'(MAX_FIELD_BYTES);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_GATHER = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic             held_valid;
  ntrl_in_t         held;
  logic [1:0]       phase, phase_next;
  logic [3:0]       count_bytes, count_bytes_next;
  logic [3:0]       offset_bytes, offset_bytes_next;
  logic [3:0]       byte_position, byte_position_next;
  logic [ACC_W-1:0] count_accum, count_accum_next;
  logic [ACC_W-1:0] delta_accum, delta_accum_next;
  logic [62:0]      running_lcn, running_lcn_next;
  logic             any_run_seen, any_run_seen_next;

  logic             fire;
  logic [7:0]       d;
  logic             fin;
  logic             bad_hdr;
  logic [3:0]       rel;
  logic [ACC_W-1:0] count_m, delta_m;
  logic [63:0]      dz, delta64;
  logic             sgn;
  logic             last_field;
  logic [64:0]      sum65;
  logic             in_range;
  logic             do_clear;
  logic [1:0]       num;
  ntrl_out_t        rec0, rec1;

  assign fire       = held_valid && room;
  assign byte_ready = !held_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      held <= byte_data;
    end
  end

  assign d   = held.data_byte;
  assign fin = held.final_byte;

  assign bad_hdr = (d[3:0] == 4'd0) || (d[3:0] > MAX_NIB) || (d[7:4] > MAX_NIB);

  // Place the current byte into its lane of the count or delta field.
  assign rel = byte_position - count_bytes;
  always_comb begin
    count_m = count_accum;
    delta_m = delta_accum;
    for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
      if (byte_position < count_bytes && byte_position == 4'(i)) begin
        count_m[8*i +: 8] = d;
      end
      if (byte_position >= count_bytes && rel == 4'(i)) begin
        delta_m[8*i +: 8] = d;
      end
    end
  end

  assign last_field = ({1'b0, byte_position} + 5'd1) >=
                      ({1'b0, count_bytes} + {1'b0, offset_bytes});

  // Sign-extend the delta from its top gathered byte.
  assign dz = 64'(delta_m);
  always_comb begin
    sgn = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (offset_bytes == 4'(i + 1)) begin
        sgn = dz[8*i + 7];
      end
    end
    for (int i = 0; i < 8; i++) begin
      delta64[8*i +: 8] = (4'(i) < offset_bytes) ? dz[8*i +: 8] : {8{sgn}};
    end
  end

  assign sum65    = {2'b00, running_lcn} + {delta64[63], delta64};
  assign in_range = (sum65[64:63] == 2'b00);

  always_comb begin
    phase_next         = phase;
    count_bytes_next   = count_bytes;
    offset_bytes_next  = offset_bytes;
    byte_position_next = byte_position;
    count_accum_next   = count_accum;
    delta_accum_next   = delta_accum;
    running_lcn_next   = running_lcn;
    any_run_seen_next  = any_run_seen;
    do_clear           = 1'b0;
    num                = 2'd0;
    rec0               = make_rec(KIND_END, ERR_NONE, '0, '0, 1'b0);
    rec1               = make_rec(KIND_END, ERR_NONE, '0, '0, 1'b0);
    if (fire) begin
      case (phase)
        PH_HEADER: begin
          if (d == 8'd0) begin
            num = 2'd1;
            if (any_run_seen) begin
              rec0 = make_rec(KIND_END, ERR_NONE, '0, '0, 1'b0);
            end else begin
              rec0 = make_rec(KIND_ERR, ERR_EMPTY, '0, '0, 1'b0);
            end
            phase_next = PH_DONE;
            do_clear   = fin;
          end else if (bad_hdr) begin
            num        = 2'd1;
            rec0       = make_rec(KIND_ERR, ERR_BAD_HEADER, '0, '0, 1'b0);
            phase_next = PH_DONE;
            do_clear   = fin;
          end else if (fin) begin
            num      = 2'd1;
            rec0     = make_rec(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b0);
            do_clear = 1'b1;
          end else begin
            count_bytes_next   = d[3:0];
            offset_bytes_next  = d[7:4];
            byte_position_next = 4'd0;
            count_accum_next   = '0;
            delta_accum_next   = '0;
            phase_next         = PH_GATHER;
          end
        end
        PH_GATHER: begin
          count_accum_next = count_m;
          delta_accum_next = delta_m;
          if (!last_field) begin
            if (fin) begin
              num      = 2'd1;
              rec0     = make_rec(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b0);
              do_clear = 1'b1;
            end else begin
              byte_position_next = byte_position + 4'd1;
            end
          end else if (count_m == '0) begin
            num        = 2'd1;
            rec0       = make_rec(KIND_ERR, ERR_ZERO_COUNT, '0, '0, 1'b0);
            phase_next = PH_DONE;
            do_clear   = fin;
          end else if (offset_bytes != 4'd0 && !in_range) begin
            // Leave the running LCN as it was.
            num        = 2'd1;
            rec0       = make_rec(KIND_ERR, ERR_LCN_RANGE, '0, '0, 1'b0);
            phase_next = PH_DONE;
            do_clear   = fin;
          end else begin
            num = 2'd1;
            if (offset_bytes != 4'd0) begin
              running_lcn_next = sum65[62:0];
              rec0 = make_rec(KIND_RUN, ERR_NONE, 64'(count_m), sum65[62:0], 1'b0);
            end else begin
              rec0 = make_rec(KIND_RUN, ERR_NONE, 64'(count_m), '0, 1'b1);
            end
            any_run_seen_next = 1'b1;
            phase_next        = PH_HEADER;
            if (fin) begin
              num      = 2'd2;
              rec1     = make_rec(KIND_END, ERR_NONE, '0, '0, 1'b0);
              do_clear = 1'b1;
            end
          end
        end
        default: begin
          do_clear = fin;
        end
      endcase
      // Rearm on the buffer's final byte.
      if (do_clear) begin
        phase_next         = PH_HEADER;
        count_bytes_next   = 4'd0;
        offset_bytes_next  = 4'd0;
        byte_position_next = 4'd0;
        count_accum_next   = '0;
        delta_accum_next   = '0;
        running_lcn_next   = '0;
        any_run_seen_next  = 1'b0;
      end
    end
    rec0.last_of_item = (num == 2'd1);
    rec1.last_of_item = (num == 2'd2);
  end

  assign push.num    = num;
  assign push.first  = rec0;
  assign push.second = rec1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      count_bytes   <= 4'd0;
      offset_bytes  <= 4'd0;
      byte_position <= 4'd0;
      count_accum   <= '0;
      delta_accum   <= '0;
      running_lcn   <= '0;
      any_run_seen  <= 1'b0;
    end else begin
      phase         <= phase_next;
      count_bytes   <= count_bytes_next;
      offset_bytes  <= offset_bytes_next;
      byte_position <= byte_position_next;
      count_accum   <= count_accum_next;
      delta_accum   <= delta_accum_next;
      running_lcn   <= running_lcn_next;
      any_run_seen  <= any_run_seen_next;
    end
  end

endmodule

// ----- sv/ntrl_outq.sv -----
// Four-entry result queue of the run list decoder; takes up to two records
// per cycle and presents one record beat. Depends on ntrl_pkg.
module ntrl_outq import ntrl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ntrl_push_t push,
  output logic       room,
  output logic       rec_valid,
  input  logic       rec_ready,
  output ntrl_out_t  rec_data
);

  ntrl_out_t  slot [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill, fill_next;
  logic       pop;

  assign pop       = rec_valid && rec_ready;
  assign rec_valid = (fill != 3'd0);
  assign rec_data  = slot[rd_ptr];
  // Room for the two records a byte can cause.
  assign room      = (fill <= 3'd2);
  assign fill_next = fill + {1'b0, push.num} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.num;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill_next;
    end
    if (push.num != 2'd0) begin
      slot[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      slot[wr_ptr + 2'd1] <= push.second;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for ntfs_run_list_decoder: scripted run lists, then random lists.
// Expected records are predicted in-bench or typed in the script, checked at the output.
// Depends on ntrl_pkg and the decoder RTL.
module tb_top;
  import ntrl_pkg::*;

  localparam int   MAX_FIELD = 8;
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef enum logic [1:0] {PH_HEADER, PH_GATHER, PH_DONE} decode_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [1:0] kind;
    logic [2:0] err;
  } script_row_t;

  logic      clk;
  logic      rst        = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  ntrl_in_t  byte_data  = '0;
  logic      rec_valid;
  logic      rec_ready  = 1'b0;
  ntrl_out_t rec_data;

  // decoder state as this bench sees it
  decode_phase_t dec_phase;
  logic [3:0]    cnt_len, off_len, field_pos;
  logic [63:0]   cnt_acc, delta_acc;
  logic [62:0]   run_lcn;
  logic          seen_run;

  ntrl_out_t  new_recs[$];
  ntrl_out_t  pending_recs[$];
  logic [7:0] list_bytes[$];
  int         live_beats = 0;
  bit         calm       = 1'b0;
  bit         failed     = 1'b0;

  // Rows with a typed record are checked against it; the rest use the predictor.
  script_row_t script [25] = '{
    {8'h00, 1'b0, TYPED,     KIND_ERR, ERR_EMPTY},
    {8'hFF, 1'b1, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h09, 1'b1, TYPED,     KIND_ERR, ERR_BAD_HEADER},
    {8'h90, 1'b1, TYPED,     KIND_ERR, ERR_BAD_HEADER},
    {8'hF1, 1'b1, TYPED,     KIND_ERR, ERR_BAD_HEADER},
    {8'h11, 1'b1, TYPED,     KIND_ERR, ERR_TRUNCATED},
    {8'h11, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h05, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h10, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h21, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h01, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'hE0, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'hFF, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h33, 1'b1, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h01, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h00, 1'b0, TYPED,     KIND_ERR, ERR_ZERO_COUNT},
    {8'hAA, 1'b1, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h01, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h07, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h00, 1'b0, TYPED,     KIND_END, ERR_NONE},
    {8'h00, 1'b1, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h01, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h03, 1'b1, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h21, 1'b0, PREDICTED, KIND_RUN, ERR_NONE},
    {8'h01, 1'b1, TYPED,     KIND_ERR, ERR_TRUNCATED}
  };

  ntfs_run_list_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec_data   (rec_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic ntrl_out_t build_rec(logic [1:0] kind, logic [2:0] err,
                                          logic [63:0] cnt, logic [62:0] lcn,
                                          logic sparse);
    ntrl_out_t r;
    r.record_kind   = kind;
    r.error_code    = err;
    r.cluster_count = cnt;
    r.start_lcn     = lcn;
    r.is_sparse     = sparse;
    r.last_of_item  = 1'b0;
    return r;
  endfunction

  // Append to the records caused by the current beat.
  function automatic void add_rec(ntrl_out_t r);
    new_recs = {new_recs, r};
  endfunction

  function automatic void add_byte(logic [7:0] b);
    list_bytes = {list_bytes, b};
  endfunction

  function automatic void log_expected(ntrl_out_t r);
    pending_recs = {pending_recs, r};
  endfunction

  function automatic void clear_state();
    dec_phase = PH_HEADER;
    cnt_len   = '0;
    off_len   = '0;
    field_pos = '0;
    cnt_acc   = '0;
    delta_acc = '0;
    run_lcn   = '0;
    seen_run  = 1'b0;
  endfunction

  // An end or error record on the final byte rearms at once.
  function automatic void close_list(logic fin);
    if (fin) clear_state();
    else dec_phase = PH_DONE;
  endfunction

  function automatic void decode_byte(ntrl_in_t b);
    logic [7:0]  d;
    int          lb, ob, at;
    logic [63:0] delta, sum, mag;
    logic [2:0]  err;
    logic [62:0] start;
    d = b.data_byte;
    new_recs = {};
    case (dec_phase)
      PH_HEADER: begin
        lb = d[3:0];
        ob = d[7:4];
        if (d == 8'h00) begin
          if (seen_run) add_rec(build_rec(KIND_END, ERR_NONE, '0, '0, 1'b0));
          else add_rec(build_rec(KIND_ERR, ERR_EMPTY, '0, '0, 1'b0));
          close_list(b.final_byte);
        end else if (lb == 0 || lb > MAX_FIELD || ob > MAX_FIELD) begin
          add_rec(build_rec(KIND_ERR, ERR_BAD_HEADER, '0, '0, 1'b0));
          close_list(b.final_byte);
        end else if (b.final_byte) begin
          add_rec(build_rec(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b0));
          close_list(b.final_byte);
        end else begin
          cnt_len   = lb[3:0];
          off_len   = ob[3:0];
          field_pos = '0;
          cnt_acc   = '0;
          delta_acc = '0;
          dec_phase = PH_GATHER;
        end
      end
      PH_GATHER: begin
        at = field_pos;
        if (at < cnt_len) cnt_acc |= 64'(d) << (8 * (at % 8));
        else delta_acc |= 64'(d) << (8 * ((at - cnt_len) % 8));
        if (at + 1 < cnt_len + off_len) begin
          if (b.final_byte) begin
            add_rec(build_rec(KIND_ERR, ERR_TRUNCATED, '0, '0, 1'b0));
            close_list(b.final_byte);
          end else begin
            field_pos = 4'(at + 1);
          end
        end else begin
          err   = ERR_NONE;
          start = '0;
          if (cnt_acc == 0) begin
            err = ERR_ZERO_COUNT;
          end else if (off_len != 0) begin
            delta = delta_acc;
            // sign-extend a short delta field
            if (off_len < 8 && delta[8 * off_len - 1]) delta |= ~64'd0 << (8 * off_len);
            if (!delta[63]) begin
              sum = {1'b0, run_lcn} + delta;
              if (sum[63]) err = ERR_LCN_RANGE;
              else run_lcn = sum[62:0];
            end else begin
              mag = -delta;
              if (mag > {1'b0, run_lcn}) err = ERR_LCN_RANGE;
              else run_lcn = run_lcn - mag[62:0];
            end
            start = run_lcn;
          end
          if (err != ERR_NONE) begin
            add_rec(build_rec(KIND_ERR, err, '0, '0, 1'b0));
            close_list(b.final_byte);
          end else begin
            add_rec(build_rec(KIND_RUN, ERR_NONE, cnt_acc, start, off_len == 0));
            seen_run = 1'b1;
            if (b.final_byte) begin
              add_rec(build_rec(KIND_END, ERR_NONE, '0, '0, 1'b0));
              clear_state();
            end else begin
              dec_phase = PH_HEADER;
            end
          end
        end
      end
      default: if (b.final_byte) clear_state();
    endcase
  endfunction

  // Mostly well-formed lists with random content; some noise, some cut short.
  function automatic void build_list();
    int         runs, lb, ob, i, j;
    bit         zero_cnt;
    logic [7:0] b8;
    list_bytes = {};
    if ($urandom_range(0, 9) == 0) begin
      runs = $urandom_range(1, 12);
      for (i = 0; i < runs; i++) add_byte(8'($urandom));
      return;
    end
    runs = $urandom_range(1, 5);
    for (i = 0; i < runs; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_byte(8'($urandom));
      end else begin
        lb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
        ob = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
        add_byte({4'(ob), 4'(lb)});
        zero_cnt = ($urandom_range(0, 15) == 0);
        for (j = 0; j < lb; j++) add_byte(zero_cnt ? 8'h00 : 8'($urandom));
        for (j = 0; j < ob; j++) begin
          b8 = 8'($urandom);
          // keep most deltas forward so lists run on
          if (j == ob - 1 && $urandom_range(0, 2) != 0) b8[7] = 1'b0;
          add_byte(b8);
        end
      end
    end
    case ($urandom_range(0, 3))
      1: add_byte(8'h00);
      2: begin
        add_byte(8'h00);
        runs = $urandom_range(1, 3);
        for (i = 0; i < runs; i++) add_byte(8'($urandom));
      end
      3: begin
        if (list_bytes.size() > 1) begin
          runs = $urandom_range(1, list_bytes.size() - 1);
          for (i = 0; i < runs; i++) void'(list_bytes.pop_back());
        end
      end
      default: ;
    endcase
  endfunction

  // Present one beat and hold it until accepted, then log what it should cause.
  task automatic send_beat(ntrl_in_t b, logic typed, logic [1:0] kind, logic [2:0] err);
    ntrl_out_t r;
    while (!calm && $urandom_range(0, 99) < 33) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    do @(posedge clk); while (!byte_ready);
    if (dec_phase != PH_DONE) live_beats++;
    decode_byte(b);
    if (typed) begin
      r = build_rec(kind, err, '0, '0, 1'b0);
      r.last_of_item = 1'b1;
      log_expected(r);
    end else begin
      foreach (new_recs[i]) begin
        r = new_recs[i];
        r.last_of_item = (i == new_recs.size() - 1);
        log_expected(r);
      end
    end
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_recs.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) rec_ready <= calm || ($urandom_range(0, 99) >= 33);

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    ntrl_out_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (pending_recs.size() == 0) begin
        $display("%0t: record expected none actual %0h", $time, rec_data);
        failed = 1'b1;
      end else begin
        want = pending_recs.pop_front();
        check_field("record_kind", 64'(want.record_kind), 64'(rec_data.record_kind));
        check_field("error_code", 64'(want.error_code), 64'(rec_data.error_code));
        check_field("cluster_count", want.cluster_count, rec_data.cluster_count);
        check_field("start_lcn", 64'(want.start_lcn), 64'(rec_data.start_lcn));
        check_field("is_sparse", 64'(want.is_sparse), 64'(rec_data.is_sparse));
        check_field("last_of_item", 64'(want.last_of_item), 64'(rec_data.last_of_item));
      end
    end
  end

  initial begin
    ntrl_in_t beat;
    bit       paused;
    int       i;
    paused = 1'b0;
    clear_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      beat.data_byte  = script[k].data;
      beat.final_byte = script[k].fin;
      send_beat(beat, script[k].typed, script[k].kind, script[k].err);
    end
    wait_drained();

    while (live_beats < 2000) begin
      calm = (live_beats >= 800 && live_beats < 1100);
      if (!paused && live_beats >= 1000) begin
        wait_drained();
        paused = 1'b1;
      end
      build_list();
      for (i = 0; i < list_bytes.size(); i++) begin
        beat.data_byte  = list_bytes[i];
        beat.final_byte = (i == list_bytes.size() - 1);
        send_beat(beat, PREDICTED, KIND_RUN, ERR_NONE);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (failed) $display("Some tests failed");
    else $display("All tests passed");
    $finish;
  end

endmodule
